FILE: hw/rtl/distance_panned_surround_mixer_core_defines.svh
// Assertion macros for the surround mixer checker.
`ifndef DISTANCE_PANNED_SURROUND_MIXER_CORE_DEFINES_SVH
`define DISTANCE_PANNED_SURROUND_MIXER_CORE_DEFINES_SVH
// Assert an implication under active-low reset.
`define DPSM_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Assert an implication whose consequent is checked in the next cycle.
`define DPSM_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/dpsm_pkg.sv
// Package: constants, types and helpers of the surround mixer.
`default_nettype none
package dpsm_pkg;
  localparam int unsigned InCh = 8;
  localparam int unsigned OutCh = 6;
  localparam int unsigned InChW = 3;
  localparam int unsigned OutChW = 3;
  localparam int unsigned QDepth = 2;

  localparam logic [1:0] FuncSample = 2'd0;
  localparam logic [1:0] FuncInSet = 2'd1;
  localparam logic [1:0] FuncOutSet = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic CfgCenterX = 1'b0;
  localparam logic CfgCenterY = 1'b1;

  localparam logic [15:0] UnityGain = 16'd4096;
  localparam logic [15:0] PosCentre = 16'd32768;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  channel;
    logic [23:0] sample;
    logic        frame_end;
    logic [15:0] gain;
    logic        mute;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } item_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [23:0] out_sample;
    logic        out_last;
  } result_t;

  // Signed speaker offsets from the centre.
  function automatic logic signed [17:0] spk_dx(input logic [OutChW-1:0] k);
    logic signed [17:0] v;
    case (k)
      3'd0: v = -18'sd16384;
      3'd2: v = 18'sd16384;
      3'd3: v = 18'sd28378;
      3'd4: v = -18'sd28378;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] spk_dy(input logic [OutChW-1:0] k);
    logic signed [17:0] v;
    case (k)
      3'd0, 3'd2: v = 18'sd28378;
      3'd1: v = 18'sd32768;
      3'd3, 3'd4: v = -18'sd16384;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/dpsm_front.sv
// Front end: takes input transactions and queues them for the engine.
`default_nettype none
module dpsm_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire dpsm_pkg::item_t in_item_i,
  output logic                 q_valid_o,
  input  wire logic            q_ready_i,
  output dpsm_pkg::item_t      q_item_o
);
  import dpsm_pkg::*;

  item_t       mem_q [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  // func 3 carries no work and is dropped here
  assign in_ready_o = (cnt_q != 2'(QDepth)) || (in_item_i.func == FuncUnused);
  assign push = in_valid_i && in_ready_o && (in_item_i.func != FuncUnused);
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/dpsm_engine.sv
// Back end: settings store, distance root, weighted accumulation, output.
`default_nettype none
module dpsm_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       center_x_i,
  input  wire logic [15:0]       center_y_i,
  input  wire logic              q_valid_i,
  output logic                   q_ready_o,
  input  wire dpsm_pkg::item_t   q_item_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output dpsm_pkg::result_t      res_o
);
  import dpsm_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StDiff  = 7'b0000010,
    StSq    = 7'b0000100,
    StRoot  = 7'b0001000,
    StMul   = 7'b0010000,
    StAcc   = 7'b0100000,
    StEmit  = 7'b1000000
  } state_e;

  state_e state_q;
  item_t  it_q;
  logic [15:0] in_gain_q [InCh];
  logic        in_mute_q [InCh];
  logic [15:0] in_px_q [InCh];
  logic [15:0] in_py_q [InCh];
  logic [15:0] out_gain_q [OutCh];
  logic        out_mute_q [OutCh];
  logic signed [47:0] acc_q [OutCh];
  logic [OutChW-1:0] k_q;
  logic signed [17:0] dx_q, dy_q;
  logic [34:0] rem_q, bit_q;
  logic [34:0] res_q;
  logic signed [40:0] scaled_q;
  logic signed [17:0] w_q;
  logic signed [59:0] prod_q;
  logic emit_busy_q;
  logic [OutChW-1:0] ek_q;
  logic signed [63:0] oprod;
  logic signed [36:0] aclamp;
  logic signed [51:0] ysh;
  logic [23:0] ysat;
  logic [InChW-1:0] ch;
  logic signed [17:0] sx, sy;

  assign ch = it_q.channel;
  assign sx = $signed({2'b00, center_x_i}) + spk_dx(k_q);
  assign sy = $signed({2'b00, center_y_i}) + spk_dy(k_q);

  assign q_ready_o = (state_q == StIdle) && !emit_busy_q;

  always_comb begin
    aclamp = (acc_q[ek_q] > 48'sd34359738368) ? 37'sd34359738368 :
             (acc_q[ek_q] < -48'sd34359738368) ? -37'sd34359738368 :
             37'(acc_q[ek_q]);
    oprod = 64'(aclamp) * $signed({1'b0, out_gain_q[ek_q]});
    ysh = 52'(oprod >>> 12);
    if (ysh > 52'sd8388607) ysat = 24'h7FFFFF;
    else if (ysh < -52'sd8388608) ysat = 24'h800000;
    else ysat = ysh[23:0];
    if (out_mute_q[ek_q]) ysat = 24'd0;
  end

  assign res_valid_o = emit_busy_q;
  assign res_o.out_channel = 3'(ek_q);
  assign res_o.out_sample = ysat;
  assign res_o.out_last = (ek_q == OutChW'(OutCh - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      emit_busy_q <= 1'b0;
      ek_q <= '0;
      k_q <= '0;
      it_q <= '0;
      dx_q <= '0;
      dy_q <= '0;
      rem_q <= '0;
      res_q <= '0;
      bit_q <= '0;
      scaled_q <= '0;
      w_q <= '0;
      prod_q <= '0;
      for (int i = 0; i < InCh; i++) begin
        in_gain_q[i] <= UnityGain;
        in_mute_q[i] <= 1'b0;
        in_px_q[i] <= PosCentre;
        in_py_q[i] <= PosCentre;
      end
      for (int i = 0; i < OutCh; i++) begin
        out_gain_q[i] <= UnityGain;
        out_mute_q[i] <= 1'b0;
        acc_q[i] <= '0;
      end
    end else begin
      if (emit_busy_q && res_ready_i) begin
        acc_q[ek_q] <= '0;
        if (ek_q == OutChW'(OutCh - 1)) begin
          emit_busy_q <= 1'b0;
          ek_q <= '0;
        end else begin
          ek_q <= ek_q + 1'b1;
        end
      end
      case (state_q)
        StIdle: begin
          if (q_valid_i && !emit_busy_q) begin
            it_q <= q_item_i;
            k_q <= '0;
            state_q <= StDiff;
            if (q_item_i.func == FuncInSet) begin
              in_gain_q[q_item_i.channel] <= q_item_i.gain;
              in_mute_q[q_item_i.channel] <= q_item_i.mute;
              in_px_q[q_item_i.channel] <= q_item_i.pos_x;
              in_py_q[q_item_i.channel] <= q_item_i.pos_y;
              state_q <= StIdle;
            end else if (q_item_i.func == FuncOutSet) begin
              if (q_item_i.channel < 3'(OutCh)) begin
                out_gain_q[q_item_i.channel] <= q_item_i.gain;
                out_mute_q[q_item_i.channel] <= q_item_i.mute;
              end
              state_q <= StIdle;
            end else if (in_mute_q[q_item_i.channel]) begin
              state_q <= StEmit;
            end
          end
        end
        StDiff: begin
          dx_q <= $signed({2'b00, in_px_q[ch]}) - sx;
          dy_q <= $signed({2'b00, in_py_q[ch]}) - sy;
          scaled_q <= 41'($signed(it_q.sample) * $signed({1'b0, in_gain_q[ch]}));
          state_q <= StSq;
        end
        StSq: begin
          rem_q <= 35'(36'(dx_q * dx_q) + 36'(dy_q * dy_q));
          res_q <= '0;
          bit_q <= 35'd1 << 34;
          state_q <= StRoot;
        end
        StRoot: begin
          if (bit_q == '0) begin
            w_q <= 18'(19'sd65536 - $signed({1'b0, res_q[17:0]}));
            state_q <= StMul;
          end else begin
            if (36'(rem_q) >= 36'(res_q) + 36'(bit_q)) begin
              rem_q <= 35'(36'(rem_q) - 36'(res_q) - 36'(bit_q));
              res_q <= 35'((36'(res_q) >> 1) + 36'(bit_q));
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        StMul: begin
          prod_q <= 60'(scaled_q * w_q);
          state_q <= StAcc;
        end
        StAcc: begin
          acc_q[k_q] <= acc_q[k_q] + 48'(prod_q >>> 28);
          if (k_q == OutChW'(OutCh - 1)) begin
            state_q <= StEmit;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= StDiff;
          end
        end
        StEmit: begin
          if (it_q.frame_end) begin
            emit_busy_q <= 1'b1;
            ek_q <= '0;
          end
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/distance_panned_surround_mixer_core.sv
// Top level of the distance-panned surround mixer.
`default_nettype none
// Streams one item per transaction. A non-muted sample holds the engine while
// each of the six speakers runs a difference, a square, a bit-pair square
// root, a multiply and an accumulate, plus a dispatch step before and a wrap-up
// step after. A muted sample goes from dispatch to wrap-up; settings writes
// take only the dispatch step. A frame end then streams six results, one a cycle while the
// receiver is ready; no new item starts until the last result is taken.
// tdata in: func[1:0] channel[4:2] sample[28:5] gain[44:29] mute[45]
// pos_x[61:46] pos_y[77:62], padded to 80 bits; tlast = frame_end.
// tdata out: out_channel[2:0] out_sample[26:3], padded to 32; tlast = out_last.
module distance_panned_surround_mixer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // func, channel, sample, gain, mute, pos_x, pos_y
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // out_channel, out_sample
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import dpsm_pkg::*;

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_ready;
  logic [15:0] cx_q, cy_q;

  assign in_item.func = s_axis_tdata[1:0];
  assign in_item.channel = s_axis_tdata[4:2];
  assign in_item.sample = s_axis_tdata[28:5];
  assign in_item.frame_end = s_axis_tlast;
  assign in_item.gain = s_axis_tdata[44:29];
  assign in_item.mute = s_axis_tdata[45];
  assign in_item.pos_x = s_axis_tdata[61:46];
  assign in_item.pos_y = s_axis_tdata[77:62];

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= PosCentre;
      cy_q <= PosCentre;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgCenterX) cx_q <= cfg_data_i;
      else cy_q <= cfg_data_i;
    end
  end

  dpsm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  dpsm_engine u_engine (
    .clk_i, .rst_ni,
    .center_x_i(cx_q), .center_y_i(cy_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {5'd0, res.out_sample, res.out_channel};
  assign m_axis_tlast = res.out_last;
endmodule
`default_nettype wire

FILE: hw/rtl/dpsm_checker.sv
// Port-level checker for the surround mixer, bound to the top level.
`default_nettype none
`include "distance_panned_surround_mixer_core_defines.svh"
module dpsm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  `DPSM_ASSERT_IMP(a_last_ch, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tdata[2:0] == 3'd5)
  `DPSM_ASSERT_IMP(a_ch_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd5)
  `DPSM_ASSERT_NXT(a_next_ch, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tdata[2:0] == $past(m_axis_tdata[2:0]) + 3'd1)
  `DPSM_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:27] == 5'd0)
endmodule
bind distance_panned_surround_mixer_core dpsm_checker u_checker (.*);
`default_nettype wire
